// File: hw/rtl/mfw_pkg.sv
// mfw_pkg: field widths, register reset values, register indexes and the
// emit-flag struct shared by the median filter window modules.
// No dependencies.
`default_nettype none

package mfw_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int OUT_COL_W    = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int SIZE_W       = 13;   // holds any effective width or height
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int MAX_HEIGHT   = 4096;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(512);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(512);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // which results a pixel produces
  typedef struct packed {
    logic med;    // window median of an earlier centre
    logic pass;   // border pixel passed straight through
  } emit_t;

endpackage

`default_nettype wire

// File: hw/rtl/mfw_ram.sv
// mfw_ram: generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
`default_nettype none

module mfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mfw_raster.sv
// mfw_raster: row/column position of each incoming pixel, line-store slot
// of its row, and which results it produces. Depends on mfw_pkg.
`default_nettype none

module mfw_raster
  import mfw_pkg::*;
#(
  parameter int KSIZE     = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [WIDTH_REG_W-1:0]            frame_width,
  input  wire logic [HEIGHT_REG_W-1:0]           frame_height,
  input  wire logic                              frame_start,
  input  wire logic                              advance,
  output logic      [ROW_W-1:0]                  row,
  output logic      [$clog2(MAX_WIDTH)-1:0]      col,
  output logic      [$clog2(KSIZE-1)-1:0]        slot,
  output emit_t                                  emit
);

  localparam int P     = KSIZE / 2;
  localparam int LINES = KSIZE - 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(LINES);

  logic [ROW_W-1:0]  row_count;
  logic [CW-1:0]     col_count;
  logic [SW-1:0]     row_slot;
  logic [ROW_W-1:0]  row_count_next;
  logic [CW-1:0]     col_count_next;
  logic [SW-1:0]     row_slot_next;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [ROW_W-1:0]  row_pre;
  logic [CW-1:0]     col_pre;
  logic [SW-1:0]     slot_pre;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;

  // clamp the programmed sizes
  always_comb begin
    if (frame_width == '0) begin
      w_eff = SIZE_W'(1);
    end else if (SIZE_W'(frame_width) > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = SIZE_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (SIZE_W'(frame_height) > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = SIZE_W'(frame_height);
    end
  end

  always_comb begin
    row_pre  = frame_start ? '0 : row_count;
    col_pre  = frame_start ? '0 : col_count;
    slot_pre = frame_start ? '0 : row_slot;
    col      = (SIZE_W'(col_pre) >= w_eff) ? '0 : col_pre;
    if (SIZE_W'(row_pre) >= h_eff) begin
      row  = '0;
      slot = '0;
    end else begin
      row  = row_pre;
      slot = slot_pre;
    end

    emit.med  = (SIZE_W'(row) >= SIZE_W'(2 * P)) && (SIZE_W'(col) >= SIZE_W'(2 * P));
    emit.pass = (SIZE_W'(row) < SIZE_W'(P)) || (SIZE_W'(col) < SIZE_W'(P)) ||
                (SIZE_W'(row) + SIZE_W'(P) >= h_eff) ||
                (SIZE_W'(col) + SIZE_W'(P) >= w_eff);

    col_inc = SIZE_W'(col) + SIZE_W'(1);
    row_inc = SIZE_W'(row) + SIZE_W'(1);
    row_count_next = row;
    row_slot_next  = slot;
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      if (row_inc >= h_eff) begin
        row_count_next = '0;
        row_slot_next  = '0;
      end else begin
        row_count_next = ROW_W'(row_inc);
        row_slot_next  = (slot == SW'(LINES - 1)) ? '0 : slot + SW'(1);
      end
    end else begin
      col_count_next = CW'(col_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      row_slot  <= '0;
    end else if (advance) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      row_slot  <= row_slot_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mfw_median.sv
// mfw_median: median of the window taps by parallel rank counting; ties are
// broken by tap position so every tap gets a distinct rank. Depends on mfw_pkg.
`default_nettype none

module mfw_median
  import mfw_pkg::*;
#(
  parameter int TAPS = 9
) (
  input  wire logic [TAPS-1:0][PIX_W-1:0] taps,
  output logic      [PIX_W-1:0]           median
);

  localparam int CNT_W = $clog2(TAPS);

  logic [TAPS-1:0] sel;

  for (genvar i = 0; i < TAPS; i++) begin : g_rank
    logic [CNT_W-1:0] cnt;
    always_comb begin
      cnt = '0;
      for (int j = 0; j < TAPS; j++) begin
        if ((taps[j] < taps[i]) || ((j < i) && (taps[j] == taps[i]))) begin
          cnt = cnt + CNT_W'(1);
        end
      end
    end
    assign sel[i] = (cnt == CNT_W'(TAPS / 2));
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < TAPS; i++) begin
      median = median | (sel[i] ? taps[i] : '0);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/median_filter_window.sv
// median_filter_window: KSIZE x KSIZE median over a raster stream of grey pixels.
// Order: a request taken passes s1, s2 and the result register before its first result;
//   a pass-through that follows a median is loaded once that median is taken.
// Throughput: one pixel per cycle while results are taken; a pixel that yields both
//   a median and a pass-through holds s2 until both are loaded into the single result register.
// Reset: position counters and pipeline valids cleared, sizes back to 512x512;
//   line stores and window are not cleared (they are written before being read).
`default_nettype none

module median_filter_window
  import mfw_pkg::*;
#(
  parameter int KSIZE     = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  // pixel requests
  input  wire logic                    pixel_valid,
  output logic                         pixel_ready,
  input  wire logic [PIX_W-1:0]        pixel_in,
  input  wire logic                    frame_start,
  // results
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output logic      [ROW_W-1:0]        out_row,
  output logic      [OUT_COL_W-1:0]    out_col,
  output logic      [PIX_W-1:0]        pixel_out,
  output logic                         is_median,
  output logic                         run_last
);

  localparam int P     = KSIZE / 2;
  localparam int LINES = KSIZE - 1;
  localparam int TAPS  = KSIZE * KSIZE;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(LINES);
  localparam int SW1   = SW + 1;

  // ---------------- configuration registers ----------------
  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake chain ----------------
  // s1: line-store read in flight; s2: window holds this pixel's column;
  // result register drains to the consumer.
  logic accept;
  logic s1_valid, s2_valid;
  logic s1_adv, s2_free, s2_done;
  logic med_pend, pass_pend;
  logic out_free, out_load;

  assign out_free    = !result_valid || result_ready;
  assign out_load    = s2_valid && (med_pend || pass_pend) && out_free;
  // s2 retires on its last result, or at once when it has none
  assign s2_done     = s2_valid && (!(med_pend || pass_pend) ||
                                    (out_free && !(med_pend && pass_pend)));
  assign s2_free     = !s2_valid || s2_done;
  assign s1_adv      = s1_valid && s2_free;
  assign pixel_ready = !s1_valid || s2_free;
  assign accept      = pixel_valid && pixel_ready;

  // ---------------- stage 0: raster position ----------------
  logic [ROW_W-1:0] pos_row;
  logic [CW-1:0]    pos_col;
  logic [SW-1:0]    pos_slot;
  emit_t            pos_emit;

  mfw_raster #(
    .KSIZE     (KSIZE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .frame_start  (frame_start),
    .advance      (accept),
    .row          (pos_row),
    .col          (pos_col),
    .slot         (pos_slot),
    .emit         (pos_emit)
  );

  // One store per slot, all read at the current column; the slot of this row
  // (which held row r-LINES) takes the new pixel in the same cycle.
  logic [PIX_W-1:0] ram_rd [LINES];

  for (genvar k = 0; k < LINES; k++) begin : g_line
    mfw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .we      (accept && (pos_slot == SW'(k))),
      .wr_addr (pos_col),
      .wr_data (pixel_in),
      .re      (accept),
      .rd_addr (pos_col),
      .rd_data (ram_rd[k])
    );
  end

  // ---------------- stage 1 ----------------
  logic [PIX_W-1:0] s1_pix;
  logic [ROW_W-1:0] s1_row;
  logic [CW-1:0]    s1_col;
  logic [SW-1:0]    s1_slot;
  emit_t            s1_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pixel_in;
      s1_row  <= pos_row;
      s1_col  <= pos_col;
      s1_slot <= pos_slot;
      s1_emit <= pos_emit;
    end
  end

  // window row i takes the store of slot (row + i) mod LINES
  logic [PIX_W-1:0] col_src [LINES];

  for (genvar i = 0; i < LINES; i++) begin : g_src
    logic [SW1-1:0] sum;
    logic [SW-1:0]  idx;
    assign sum        = SW1'(s1_slot) + SW1'(i);
    assign idx        = (sum >= SW1'(LINES)) ? SW'(sum - SW1'(LINES)) : SW'(sum);
    assign col_src[i] = ram_rd[idx];
  end

  // ---------------- stage 2: window ----------------
  logic [PIX_W-1:0] win [KSIZE][KSIZE];
  logic [PIX_W-1:0] s2_pix;
  logic [ROW_W-1:0] s2_row;
  logic [CW-1:0]    s2_col;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      for (int i = 0; i < LINES; i++) begin
        win[i][KSIZE-1] <= col_src[i];
      end
      win[LINES][KSIZE-1] <= s1_pix;
      s2_pix <= s1_pix;
      s2_row <= s1_row;
      s2_col <= s1_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      med_pend  <= 1'b0;
      pass_pend <= 1'b0;
    end else if (s1_adv) begin
      s2_valid  <= 1'b1;
      med_pend  <= s1_emit.med;
      pass_pend <= s1_emit.pass;
    end else begin
      if (s2_done) begin
        s2_valid <= 1'b0;
      end
      if (out_load && med_pend) begin
        med_pend <= 1'b0;
      end
    end
  end

  logic [TAPS-1:0][PIX_W-1:0] taps;
  logic [PIX_W-1:0]           med_val;

  for (genvar i = 0; i < KSIZE; i++) begin : g_tap_row
    for (genvar j = 0; j < KSIZE; j++) begin : g_tap_col
      assign taps[i*KSIZE+j] = win[i][j];
    end
  end

  mfw_median #(
    .TAPS (TAPS)
  ) u_median (
    .taps   (taps),
    .median (med_val)
  );

  // ---------------- result register ----------------
  // median goes first; pass-through follows and closes the run
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (med_pend) begin
        out_row   <= s2_row - ROW_W'(P);
        out_col   <= OUT_COL_W'(s2_col - CW'(P));
        pixel_out <= med_val;
        is_median <= 1'b1;
        run_last  <= !pass_pend;
      end else begin
        out_row   <= s2_row;
        out_col   <= OUT_COL_W'(s2_col);
        pixel_out <= s2_pix;
        is_median <= 1'b0;
        run_last  <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // a median that does not close its run is followed at once by the pass-through
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && is_median && !run_last
    |=> result_valid && !is_median && run_last)
    else $error("pass-through did not follow its median");

  // a pass-through result always closes its run
  a_pass_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_median |-> run_last)
    else $error("pass-through result without run_last");

  // nothing is taken while both pipeline stages are blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid && !s2_done |-> !pixel_ready)
    else $error("request taken into a blocked pipeline");
`endif

endmodule

`default_nettype wire

// File: test/median_filter_window_tb.sv
// median_filter_window_tb: self-checking bench for the 3x3 median filter window.
// Predicts medians and border pass-throughs for every pixel request taken.
// Depends on mfw_pkg and median_filter_window, which brings in mfw_raster, mfw_ram, mfw_median.

module median_filter_window_tb
  import mfw_pkg::*;
();

  localparam int KSIZE        = 3;
  localparam int MAX_WIDTH    = 1024;
  localparam int HALF         = KSIZE / 2;
  localparam int LINES        = KSIZE - 1;
  localparam int TAPS         = KSIZE * KSIZE;
  localparam int RANDOM_ITEMS = 260;
  localparam int STALL_LIMIT  = 2000;   // cycles with no request, result or size write taken
  localparam int IDLE_GAP     = 8;      // lets the pipeline flush before a size write
  localparam int DRAIN_CYCLES = 10;

  // one filter output: where it lands and what it holds
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic [PIX_W-1:0]     pix;
    logic                 med;
    logic                 last;
  } filt_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_ready;
  logic [PIX_W-1:0]      pixel_in = '0;
  logic                  frame_start = 1'b0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic [PIX_W-1:0]      pixel_out;
  logic                  is_median;
  logic                  run_last;

  median_filter_window #(
    .KSIZE     (KSIZE),
    .MAX_WIDTH (MAX_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_in     (pixel_in),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .pixel_out    (pixel_out),
    .is_median    (is_median),
    .run_last     (run_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --- filter shadow: line stores, window, position and frame sizes ---
  logic [PIX_W-1:0]        line_mem [LINES][MAX_WIDTH];
  logic [PIX_W-1:0]        win [TAPS];
  int unsigned             row_pos = 0;
  int unsigned             col_pos = 0;
  logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  // each line store is written from column 0 upwards, so its written part is
  // a prefix; this holds the length of that prefix per store
  int unsigned             written_cols [LINES] = '{default: 0};
  filt_out_t               due_outputs [$];

  int err_count       = 0;
  int pixels_sent     = 0;
  int medians_checked = 0;
  int passes_checked  = 0;
  int size_writes     = 0;
  int burst_left      = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  // middle element of the window in ascending order
  function automatic logic [PIX_W-1:0] window_median();
    logic [PIX_W-1:0] v [TAPS];
    logic [PIX_W-1:0] x;
    int               j;
    v = win;
    for (int i = 1; i < TAPS; i++) begin
      x = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > x) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = x;
    end
    return v[TAPS / 2];
  endfunction

  // advance the shadow by one pixel and queue the outputs it is due to give
  task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned w, h, r, c;
    filt_out_t   o;
    filt_out_t   outs [$];
    w = active_width();
    h = active_height();
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;

    // window moves one column left; new right column from the stores and pix
    for (int i = 0; i < KSIZE; i++)
      for (int j = 0; j < KSIZE - 1; j++)
        win[i * KSIZE + j] = win[i * KSIZE + j + 1];
    for (int i = 0; i < LINES; i++)
      win[i * KSIZE + KSIZE - 1] = line_mem[(r + i) % LINES][c];
    win[TAPS - 1] = pix;
    // the store of row r-2 has been read, row r takes its place
    line_mem[r % LINES][c] = pix;
    if (written_cols[r % LINES] < c + 1) written_cols[r % LINES] = c + 1;

    // median of the earlier centre first, then this pixel on the border
    if (r >= 2 * HALF && c >= 2 * HALF) begin
      o.row  = ROW_W'(r - HALF);
      o.col  = OUT_COL_W'(c - HALF);
      o.pix  = window_median();
      o.med  = 1'b1;
      o.last = 1'b0;
      outs   = {outs, o};
    end
    if (r < HALF || c < HALF || r + HALF >= h || c + HALF >= w) begin
      o.row  = ROW_W'(r);
      o.col  = OUT_COL_W'(c);
      o.pix  = pix;
      o.med  = 1'b0;
      o.last = 1'b0;
      outs   = {outs, o};
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) due_outputs = {due_outputs, outs[k]};

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // one pixel request; the sender works in bursts with random gaps between
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    if (burst_left == 0) begin
      // now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pixel_valid <= 1'b1;
    pixel_in    <= pix;
    frame_start <= fs;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    filter_pixel(pix, fs);
    burst_left--;
    pixels_sent++;
  endtask

  // sizes change only with the block idle: nothing due and the pipe flushed,
  // since an interior pixel may still be in flight with no result to wait on
  task automatic program_size(input bit do_w, input bit do_h,
                              input logic [CFG_DATA_W-1:0] wv,
                              input logic [CFG_DATA_W-1:0] hv);
    pixel_valid <= 1'b0;
    burst_left = 0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_data  <= wv;
      @(posedge clk);
      width_reg = wv[WIDTH_REG_W-1:0];
      size_writes++;
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_data  <= hv;
      @(posedge clk);
      height_reg = hv[HEIGHT_REG_W-1:0];
      size_writes++;
    end
    cfg_we <= 1'b0;
  endtask

  // --- result side: stall pattern and field-by-field check ---
  task automatic check_result();
    filt_out_t want;
    if (due_outputs.size() == 0) begin
      $error("unexpected result at row %0d col %0d value %0d", out_row, out_col, pixel_out);
      err_count++;
      return;
    end
    want = due_outputs.pop_front();
    if (out_row !== want.row) begin
      $error("out_row: expected %0d, got %0d", want.row, out_row);
      err_count++;
    end
    if (out_col !== want.col) begin
      $error("out_col: expected %0d, got %0d", want.col, out_col);
      err_count++;
    end
    if (pixel_out !== want.pix) begin
      $error("pixel_out: expected %0d, got %0d", want.pix, pixel_out);
      err_count++;
    end
    if (is_median !== want.med) begin
      $error("is_median: expected %0d, got %0d", want.med, is_median);
      err_count++;
    end
    if (run_last !== want.last) begin
      $error("run_last: expected %0d, got %0d", want.last, run_last);
      err_count++;
    end
    if (want.med) medians_checked++;
    else passes_checked++;
  endtask

  // receiver modes, each picked at random: always ready, short stalls,
  // long stalls
  int ready_hold = 0;
  int recv_mode  = 0;
  int recv_cycle = 0;

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result();
    if (recv_cycle % 200 == 0) recv_mode = $urandom_range(0, 2);
    recv_cycle++;
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (recv_mode == 0) begin
      result_ready <= 1'b1;
      ready_hold = $urandom_range(10, 40);
    end else if (result_ready) begin
      result_ready <= 1'b0;
      ready_hold = (recv_mode == 1) ? $urandom_range(0, 2) : $urandom_range(3, 12);
    end else begin
      result_ready <= 1'b1;
      ready_hold = $urandom_range(0, 6);
    end
  end

  // watchdog: too long with nothing taken on either side means a hang
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_we || (pixel_valid && pixel_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without progress, %0d outputs still due",
               idle_cycles, due_outputs.size());
      $display("FAILURE");
      $finish;
    end
  end

  // --- tests ---

  // sizes at reset are 512x512 and the position starts at 0,0
  task automatic test_reset_size();
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
  endtask

  // smallest frame with a median; last pixel gives median then pass-through,
  // the centre pixel gives nothing at its own request
  task automatic test_three_by_three();
    logic [PIX_W-1:0] vals [TAPS] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFE,
                                      8'h7F, 8'h55, 8'hAA, 8'h07};
    program_size(1'b1, 1'b1, CFG_DATA_W'(3), CFG_DATA_W'(3));
    foreach (vals[k]) send_pixel(vals[k], k == 0);
  endtask

  // after the last row the next frame starts unmarked; frame_start forces 0,0
  task automatic test_counter_wrap();
    send_pixel(8'h3C, 1'b0);
    send_pixel(8'hC3, 1'b0);
    send_pixel(8'h5A, 1'b1);
  endtask

  // zero sizes act as one: every pixel lands on 0,0
  task automatic test_zero_sizes();
    program_size(1'b1, 1'b1, '0, '0);
    send_pixel(8'h81, 1'b0);
    send_pixel(8'h18, 1'b0);
  endtask

  // sizes above range clip; upper data bits beyond the width field are dropped
  task automatic test_oversize();
    program_size(1'b1, 1'b1, '1, CFG_DATA_W'(8191));
    send_pixel(8'hF0, 1'b1);
    send_pixel(8'h0F, 1'b0);
    send_pixel(8'hE7, 1'b0);
  endtask

  // one full row at the widest size, reaching the last column
  task automatic test_full_width_row();
    program_size(1'b1, 1'b1, CFG_DATA_W'(MAX_WIDTH), CFG_DATA_W'(MAX_HEIGHT));
    for (int k = 0; k < MAX_WIDTH + 6; k++) send_pixel(PIX_W'($urandom), k == 0);
  endtask

  // random sizes and frames: mostly well-formed frames with random content,
  // some picked up mid-frame after a size change, some stray frame starts
  task automatic test_random_frames();
    int unsigned           sent, n_pix, area, w, h, vmode, base;
    logic [CFG_DATA_W-1:0] wv, hv;
    bit                    do_w, do_h, fs_first, fs;
    logic [PIX_W-1:0]      pix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      do_w = ($urandom_range(0, 9) < 6);
      do_h = ($urandom_range(0, 9) < 5);
      case ($urandom_range(0, 11))
        0:       wv = '0;
        1:       wv = CFG_DATA_W'(1);
        2:       wv = CFG_DATA_W'(2);
        3:       wv = CFG_DATA_W'(3);
        4:       wv = CFG_DATA_W'($urandom_range(MAX_WIDTH, 2047));
        default: wv = CFG_DATA_W'($urandom_range(4, 12));
      endcase
      // not part of the width
      wv[CFG_DATA_W-1:WIDTH_REG_W] = (CFG_DATA_W - WIDTH_REG_W)'($urandom);
      case ($urandom_range(0, 11))
        0:       hv = '0;
        1:       hv = CFG_DATA_W'(1);
        2:       hv = CFG_DATA_W'(2);
        3:       hv = CFG_DATA_W'(MAX_HEIGHT);
        4:       hv = CFG_DATA_W'($urandom_range(MAX_HEIGHT + 1, 8191));
        default: hv = CFG_DATA_W'($urandom_range(3, 10));
      endcase
      if (do_w || do_h) program_size(do_w, do_h, wv, hv);
      w = active_width();
      h = active_height();
      // carrying on mid-frame is only safe if both stores already hold the
      // full width; otherwise a median would see store entries never written
      fs_first = ($urandom_range(0, 9) < 7) || w > written_cols[0] || w > written_cols[1];
      area = (w * h > 200) ? 200 : w * h;
      n_pix = $urandom_range(1, (2 * area + 2 > 120) ? 120 : 2 * area + 2);
      vmode = $urandom_range(0, 2);
      base  = $urandom_range(0, 255);
      for (int k = 0; k < n_pix; k++) begin
        case (vmode)
          0: pix = PIX_W'($urandom);
          1: begin
            // few levels, so the window holds many equal values
            case ($urandom_range(0, 2))
              0:       pix = 8'h00;
              1:       pix = 8'hFF;
              default: pix = PIX_W'(base);
            endcase
          end
          default: pix = PIX_W'(base + $urandom_range(0, 15) - 8);
        endcase
        fs = (k == 0 && fs_first) || ($urandom_range(0, 149) == 0);
        send_pixel(pix, fs);
      end
      sent += n_pix;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_three_by_three();
    test_counter_wrap();
    test_zero_sizes();
    test_oversize();
    test_full_width_row();
    test_random_frames();

    pixel_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels over %0d size writes; checked %0d medians and %0d border pixels.",
             pixels_sent, size_writes, medians_checked, passes_checked);
    $display("%0d field mismatches or unexpected results.", err_count);
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
